// ===== rtl/atsj_pkg.sv =====
`timescale 1ns / 1ps
package atsj_pkg;

  // Internal fixed point: signed Q2.30.
  localparam int unsigned QF        = 30;
  localparam logic [31:0] ONE_Q     = 32'h4000_0000;
  localparam logic [60:0] HALF_Q    = 61'h2000_0000;
  localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
  localparam logic [29:0] OCT_HALF  = 30'h2000_0000;

  // Output field widths.
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned DERIV_W  = 18;

  // Register reset and word sequencing.
  localparam logic [7:0] TOL_RESET = 8'd4;
  localparam logic [1:0] LAST_IDX  = 2'd3;

  // Quadrant codes of a reduced angle.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Running state of one sine/cosine series step.
  typedef struct packed {
    logic        v;
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x2;
    logic [30:0] s;
    logic [30:0] c;
    logic [30:0] ts;
    logic [30:0] tc;
  } atsj_acc_t;

  // Weights and Jacobian rows in Q2.30.
  typedef struct packed {
    logic [3:0][31:0]      w;
    logic [3:0][2:0][31:0] d;
  } atsj_res_t;

  // One input item's results at field width.
  typedef struct packed {
    logic [3:0][WEIGHT_W-1:0]      w;
    logic [3:0][2:0][DERIV_W-1:0]  d;
    logic                          bad;
  } atsj_item_t;

  // Sign-magnitude product, magnitude rounded half up at bit 30.
  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic        neg;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [31:0] m;
    neg = (a < 0) != (b < 0);
    ma  = 31'(a < 0 ? -a : a);
    mb  = 31'(b < 0 ? -b : b);
    p   = 62'(ma) * 62'(mb);
    m   = 32'((p + 62'(HALF_Q)) >> QF);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== rtl/atsj_sincos.sv =====
`timescale 1ns / 1ps
module atsj_sincos import atsj_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [15:0]        angle_i,
  output logic               valid_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  // Reduce the angle to an octant and a quadrant.
  logic [23:0] ang_ext;
  logic [31:0] turn;
  logic [29:0] rfrac;
  logic        swap_d;
  logic [29:0] roct;
  assign ang_ext = {8'd0, angle_i};
  assign turn    = 32'(ang_ext[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
  assign rfrac   = turn[29:0];
  assign swap_d  = rfrac > OCT_HALF;
  assign roct    = swap_d ? 30'(31'h4000_0000 - {1'b0, rfrac}) : rfrac;

  // Stage 1: octant fraction times pi/2.
  logic        v1_q;
  logic [1:0]  quad1_q;
  logic        swap1_q;
  logic [60:0] xprod1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad1_q  <= turn[31:30];
      swap1_q  <= swap_d;
      xprod1_q <= 61'(roct) * 61'(HALF_PI_Q);
    end
  end

  // Stage 2: x in radians, then x squared.
  logic [29:0] x_d;
  logic        v2_q;
  logic [1:0]  quad2_q;
  logic        swap2_q;
  logic [29:0] x2st_q;
  logic [59:0] xx2_q;
  assign x_d = 30'((xprod1_q + HALF_Q) >> QF);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad2_q <= quad1_q;
      swap2_q <= swap1_q;
      x2st_q  <= x_d;
      xx2_q   <= 60'(x_d) * 60'(x_d);
    end
  end

  // Stage 3: round x squared and seed both series.
  atsj_acc_t acc_q [0:6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
    end else if (en_i) begin
      acc_q[0].v    <= v2_q;
      acc_q[0].quad <= quad2_q;
      acc_q[0].swap <= swap2_q;
      acc_q[0].x2   <= 30'((61'(xx2_q) + HALF_Q) >> QF);
      acc_q[0].s    <= 31'(x2st_q);
      acc_q[0].ts   <= 31'(x2st_q);
      acc_q[0].c    <= 31'(ONE_Q);
      acc_q[0].tc   <= 31'(ONE_Q);
    end
  end

  // Six series steps, three stages each: product, reciprocal, correct and add.
  for (genvar k = 1; k <= 6; k++) begin : g_step
    localparam int unsigned KS  = (2 * k) * (2 * k + 1);
    localparam int unsigned KC  = (2 * k - 1) * (2 * k);
    localparam int unsigned SHS = 31 + $clog2(KS);
    localparam int unsigned SHC = 31 + $clog2(KC);
    localparam logic [31:0] MS  = 32'((64'd1 << SHS) / KS);
    localparam logic [31:0] MC  = 32'((64'd1 << SHC) / KC);

    atsj_acc_t   a_q;
    atsj_acc_t   b_q;
    logic [60:0] ps_q;
    logic [60:0] pc_q;
    logic [30:0] rs_d;
    logic [30:0] rc_d;
    logic [30:0] rs_q;
    logic [30:0] rc_q;
    logic [62:0] ms_q;
    logic [62:0] mc_q;
    logic [30:0] qs;
    logic [30:0] qc;
    logic [30:0] rem_s;
    logic [30:0] rem_c;
    logic [30:0] qs_f;
    logic [30:0] qc_f;
    atsj_acc_t   acc_d;

    // Term times x squared.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_q <= '0;
      end else if (en_i) begin
        a_q <= acc_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ps_q <= 61'(acc_q[k-1].ts) * 61'(acc_q[k-1].x2);
        pc_q <= 61'(acc_q[k-1].tc) * 61'(acc_q[k-1].x2);
      end
    end

    // Round, then multiply by the divisor's reciprocal.
    assign rs_d = 31'((ps_q + HALF_Q) >> QF);
    assign rc_d = 31'((pc_q + HALF_Q) >> QF);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_q <= '0;
      end else if (en_i) begin
        b_q <= a_q;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rs_q <= rs_d;
        rc_q <= rc_d;
        ms_q <= 63'(rs_d) * 63'(MS);
        mc_q <= 63'(rc_d) * 63'(MC);
      end
    end

    // The estimate is exact or one low; one compare fixes it.
    assign qs    = 31'(ms_q >> SHS);
    assign qc    = 31'(mc_q >> SHC);
    assign rem_s = rs_q - 31'(qs * 31'(KS));
    assign rem_c = rc_q - 31'(qc * 31'(KC));
    assign qs_f  = (rem_s >= 31'(KS)) ? qs + 31'd1 : qs;
    assign qc_f  = (rem_c >= 31'(KC)) ? qc + 31'd1 : qc;

    always_comb begin
      acc_d    = b_q;
      acc_d.ts = qs_f;
      acc_d.tc = qc_f;
      if ((k % 2) == 1) begin
        acc_d.s = b_q.s - qs_f;
        acc_d.c = b_q.c - qc_f;
      end else begin
        acc_d.s = b_q.s + qs_f;
        acc_d.c = b_q.c + qc_f;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[k] <= '0;
      end else if (en_i) begin
        acc_q[k] <= acc_d;
      end
    end
  end

  // Undo the octant swap and apply the quadrant signs.
  logic signed [31:0] so;
  logic signed [31:0] co;
  logic signed [31:0] sin_d;
  logic signed [31:0] cos_d;
  assign so = acc_q[6].swap ? $signed({1'b0, acc_q[6].c}) : $signed({1'b0, acc_q[6].s});
  assign co = acc_q[6].swap ? $signed({1'b0, acc_q[6].s}) : $signed({1'b0, acc_q[6].c});
  always_comb begin
    case (acc_q[6].quad)
      QUAD_0: begin
        sin_d = so;
        cos_d = co;
      end
      QUAD_1: begin
        sin_d = co;
        cos_d = -so;
      end
      QUAD_2: begin
        sin_d = -so;
        cos_d = -co;
      end
      default: begin
        sin_d = -co;
        cos_d = so;
      end
    endcase
  end

  logic               vo_q;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= acc_q[6].v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign valid_o = vo_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

// ===== rtl/atsj_jacob.sv =====
`timescale 1ns / 1ps
module atsj_jacob import atsj_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2:0][31:0] sin_i,
  input  logic [2:0][31:0] cos_i,
  output logic             valid_o,
  output atsj_res_t        res_o
);

  // Level 1: squares and doubled products of each angle.
  logic             v1_q;
  logic [2:0][31:0] sq_q;
  logic [2:0][31:0] cq_q;
  logic [2:0][31:0] pp_q;
  logic [2:0][31:0] sc_d;
  for (genvar i = 0; i < 3; i++) begin : g_l1
    assign sc_d[i] = qmul(sin_i[i], cos_i[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[i] <= qmul(sin_i[i], sin_i[i]);
        cq_q[i] <= qmul(cos_i[i], cos_i[i]);
        pp_q[i] <= {sc_d[i][30:0], 1'b0};
      end
    end
  end

  // Level 2: first products of the chains.
  logic        v2_q;
  logic [31:0] sab_q, w0_q, w1_q, d00_q, d10_q, d11_q;
  logic [31:0] t20_q, t21_q, t22_q, sq1_q, sq2_q, cq2_q;
  logic [31:0] t21_d;
  assign t21_d = qmul(pp_q[1], sq_q[0]);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sab_q <= qmul(sq_q[0], sq_q[1]);
      w0_q  <= cq_q[0];
      w1_q  <= qmul(sq_q[0], cq_q[1]);
      d00_q <= -$signed(pp_q[0]);
      d10_q <= qmul(pp_q[0], cq_q[1]);
      d11_q <= -$signed(t21_d);
      t20_q <= qmul(pp_q[0], sq_q[1]);
      t21_q <= t21_d;
      t22_q <= qmul(pp_q[2], sq_q[0]);
      sq1_q <= sq_q[1];
      sq2_q <= sq_q[2];
      cq2_q <= cq_q[2];
    end
  end

  // Level 3: second products and assembly of the rows.
  logic        v3_q;
  atsj_res_t   res_q;
  logic [31:0] t32_d;
  assign t32_d = qmul(t22_q, sq1_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.w[0]    <= w0_q;
      res_q.w[1]    <= w1_q;
      res_q.w[2]    <= qmul(sab_q, cq2_q);
      res_q.w[3]    <= qmul(sab_q, sq2_q);
      res_q.d[0][0] <= d00_q;
      res_q.d[0][1] <= '0;
      res_q.d[0][2] <= '0;
      res_q.d[1][0] <= d10_q;
      res_q.d[1][1] <= d11_q;
      res_q.d[1][2] <= '0;
      res_q.d[2][0] <= qmul(t20_q, cq2_q);
      res_q.d[2][1] <= qmul(t21_q, cq2_q);
      res_q.d[2][2] <= -$signed(t32_d);
      res_q.d[3][0] <= qmul(t20_q, sq2_q);
      res_q.d[3][1] <= qmul(t21_q, sq2_q);
      res_q.d[3][2] <= t32_d;
    end
  end

  // Valid bits for the three levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/atsj_outconv.sv =====
`timescale 1ns / 1ps
module atsj_outconv import atsj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  atsj_res_t  res_i,
  input  logic [7:0] tol_i,
  output logic       valid_o,
  output atsj_item_t item_o
);

  localparam int unsigned OUT_SHIFT  = QF - FRAC_BITS;
  localparam logic [31:0] ROUND_HALF = 32'((64'd1 << OUT_SHIFT) >> 1);
  localparam logic [33:0] UNIT       = 34'(64'd1 << FRAC_BITS);

  // Clamp to one and round the magnitude half up.
  function automatic logic [31:0] to_out(logic signed [31:0] v);
    logic signed [31:0] cl;
    logic [31:0]        m;
    cl = v;
    if (v > $signed(ONE_Q)) cl = $signed(ONE_Q);
    if (v < -$signed(ONE_Q)) cl = -$signed(ONE_Q);
    m = (32'(cl < 0 ? -cl : cl) + ROUND_HALF) >> OUT_SHIFT;
    return (cl < 0) ? 32'(-$signed(m)) : m;
  endfunction

  // Stage A: convert every value.
  logic                  va_q;
  logic [3:0][31:0]      wo_q;
  logic [3:0][2:0][31:0] do_q;
  for (genvar i = 0; i < 4; i++) begin : g_conv
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wo_q[i] <= to_out(res_i.w[i]);
        for (int j = 0; j < 3; j++) begin
          do_q[i][j] <= to_out(res_i.d[i][j]);
        end
      end
    end
  end

  // Stage B: sum of weights against the tolerance, zero weights, field widths.
  logic signed [33:0] sum;
  logic signed [33:0] dev;
  logic [33:0]        dev_mag;
  logic               zero_w;
  atsj_item_t         item_d;
  assign sum = $signed(34'(wo_q[0])) + $signed(34'(wo_q[1]))
             + $signed(34'(wo_q[2])) + $signed(34'(wo_q[3]));
  assign dev     = sum - $signed(UNIT);
  assign dev_mag = 34'(dev < 0 ? -dev : dev);
  assign zero_w  = (wo_q[0] == '0) || (wo_q[1] == '0) || (wo_q[2] == '0) || (wo_q[3] == '0);
  always_comb begin
    item_d.bad = zero_w || (dev_mag > 34'(tol_i));
    for (int i = 0; i < 4; i++) begin
      item_d.w[i] = wo_q[i][WEIGHT_W-1:0];
      for (int j = 0; j < 3; j++) begin
        item_d.d[i][j] = do_q[i][j][DERIV_W-1:0];
      end
    end
  end

  logic       vb_q;
  atsj_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  assign valid_o = vb_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/atsj_ser.sv =====
`timescale 1ns / 1ps
module atsj_ser import atsj_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  atsj_item_t          item_i,
  output logic                take_o,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [1:0]          index_o,
  output logic [WEIGHT_W-1:0] weight_o,
  output logic [DERIV_W-1:0]  da_o,
  output logic [DERIV_W-1:0]  db_o,
  output logic [DERIV_W-1:0]  dc_o,
  output logic                bad_o,
  output logic                last_o
);

  logic       busy_q;
  logic [1:0] cnt_q;
  atsj_item_t item_q;
  logic       fire;
  logic       done;
  logic       load;

  // A new item loads when none is held or as the held one sends its last word.
  assign fire   = busy_q && !stall_i;
  assign done   = fire && (cnt_q == LAST_IDX);
  assign take_o = !busy_q || done;
  assign load   = valid_i && take_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  // Present the row selected by the word count.
  assign valid_o  = busy_q;
  assign index_o  = cnt_q;
  assign weight_o = item_q.w[cnt_q];
  assign da_o     = item_q.d[cnt_q][0];
  assign db_o     = item_q.d[cnt_q][1];
  assign dc_o     = item_q.d[cnt_q][2];
  assign bad_o    = item_q.bad;
  assign last_o   = (cnt_q == LAST_IDX);

endmodule

// ===== rtl/angles_to_simplex_with_jacobian.sv =====
`timescale 1ns / 1ps
// Maps three angles (fractions of a full turn) to four composition weights,
// cos^2 a, sin^2 a cos^2 b, sin^2 a sin^2 b cos^2 c and sin^2 a sin^2 b sin^2 c,
// each sent as one output word with its Jacobian row by a, b and c in signed
// Q1.16; the fourth word carries last, and all four carry the invalid flag.
// An input word is taken in any cycle the pipeline can move; the output
// channel sends one word per cycle while it is not stalled, and each input
// word yields four output words, so the output port sets the sustained rate.
// From input to the first output word a word passes the sine/cosine series
// (six steps of three stages), the products, conversion and the sum check,
// and the output holding register. A stall on the output holds the whole
// pipeline once its last stage holds a word; nothing is dropped.
module angles_to_simplex_with_jacobian import atsj_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [7:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [15:0]                angle_a_i,
  input  logic [15:0]                angle_b_i,
  input  logic [15:0]                angle_c_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 component_index_o,
  output logic [WEIGHT_W-1:0]        weight_o,
  output logic signed [DERIV_W-1:0]  deriv_by_a_o,
  output logic signed [DERIV_W-1:0]  deriv_by_b_o,
  output logic signed [DERIV_W-1:0]  deriv_by_c_o,
  output logic                       invalid_o,
  output logic                       last_o
);

  // Sum tolerance register.
  logic [7:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // The pipeline moves unless its last stage holds a word the output cannot take.
  logic       en;
  logic       oc_v;
  logic       ser_take;
  assign en         = !(oc_v && !ser_take);
  assign in_stall_o = !en;

  // Sine and cosine of each angle.
  logic [15:0]      angles [3];
  logic [2:0]       sc_v;
  logic [2:0][31:0] sn;
  logic [2:0][31:0] cs;
  assign angles[0] = angle_a_i;
  assign angles[1] = angle_b_i;
  assign angles[2] = angle_c_i;
  for (genvar i = 0; i < 3; i++) begin : g_sc
    atsj_sincos #(
      .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(in_valid_i),
      .angle_i(angles[i]),
      .valid_o(sc_v[i]),
      .sin_o  (sn[i]),
      .cos_o  (cs[i])
    );
  end

  // Weights and Jacobian.
  logic      jb_v;
  atsj_res_t res;
  atsj_jacob u_jacob (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(&sc_v),
    .sin_i  (sn),
    .cos_i  (cs),
    .valid_o(jb_v),
    .res_o  (res)
  );

  // Conversion to output format and composition check.
  atsj_item_t item;
  atsj_outconv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_outconv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(jb_v),
    .res_i  (res),
    .tol_i  (tol_q),
    .valid_o(oc_v),
    .item_o (item)
  );

  // Four output words per item.
  logic [DERIV_W-1:0] da;
  logic [DERIV_W-1:0] db;
  logic [DERIV_W-1:0] dc;
  atsj_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (oc_v),
    .item_i  (item),
    .take_o  (ser_take),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .index_o (component_index_o),
    .weight_o(weight_o),
    .da_o    (da),
    .db_o    (db),
    .dc_o    (dc),
    .bad_o   (invalid_o),
    .last_o  (last_o)
  );
  assign deriv_by_a_o = $signed(da);
  assign deriv_by_b_o = $signed(db);
  assign deriv_by_c_o = $signed(dc);

endmodule

// ===== rtl/atsj_checker.sv =====
`timescale 1ns / 1ps
module atsj_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] component_index_o,
  input logic       last_o
);

  // The last flag marks exactly the fourth word.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (component_index_o == 2'd3)))
    else $error("last flag does not match word index");

  // A stalled word stays on the port.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(component_index_o))
    else $error("stalled output word changed");

  // Words of one item follow without gaps.
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o
      |=> out_valid_o && (component_index_o == $past(component_index_o) + 2'd1))
    else $error("output word sequence broken");

  // A new item always starts with its first word.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o || (component_index_o == 2'd0))
    else $error("item does not start with word zero");

endmodule

bind angles_to_simplex_with_jacobian atsj_checker u_atsj_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .component_index_o(component_index_o),
  .last_o           (last_o)
);

// ===== dv/angles_to_simplex_with_jacobian_tb.sv =====
`timescale 1ns / 1ps
module angles_to_simplex_with_jacobian_tb;
  import atsj_pkg::*;

  localparam int TIMEOUT_CYCLES = 4000;
  localparam int TOTAL_RANDOM   = 320;
  localparam int LONG_HOLD      = 300;

  // One expected output word.
  typedef struct packed {
    logic [1:0]          idx;
    logic [WEIGHT_W-1:0] w;
    logic [DERIV_W-1:0]  da;
    logic [DERIV_W-1:0]  db;
    logic [DERIV_W-1:0]  dc;
    logic                bad;
    logic                last;
  } word_t;

  // Directed row: angles, and optionally (has_w0) a typed-in weight for word 0.
  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic        has_w0;
    logic [16:0] w0;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] angle_a_i = '0, angle_b_i = '0, angle_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] component_index_o;
  logic [WEIGHT_W-1:0] weight_o;
  logic signed [DERIV_W-1:0] deriv_by_a_o, deriv_by_b_o, deriv_by_c_o;
  logic invalid_o, last_o;

  angles_to_simplex_with_jacobian i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .angle_a_i, .angle_b_i, .angle_c_i, .out_valid_o, .out_stall_i,
    .component_index_o, .weight_o, .deriv_by_a_o, .deriv_by_b_o, .deriv_by_c_o,
    .invalid_o, .last_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  word_t expected_words[$];
  logic [7:0] tol_model = TOL_RESET;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_long = 0;

  // Sign-magnitude Q30 product, magnitude rounded half up.
  function automatic longint mulq30(longint x, longint y);
    longint unsigned mx, my, p;
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    p = (mx * my + 64'h2000_0000) >> 30;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // Signed sine and cosine in Q30 of a 16-bit turn fraction.
  task automatic turn_sincos(input logic [15:0] ang, output longint sn, output longint cs);
    longint unsigned t, r, x, x2, term, s, c, tmp;
    logic [1:0] quad;
    bit swap;
    t = longint'(ang) << 16;
    quad = t[31:30];
    r = t & 64'h3FFF_FFFF;
    swap = r > 64'h2000_0000;
    if (swap) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713 + 64'h2000_0000) >> 30;
    x2 = (x * x + 64'h2000_0000) >> 30;
    term = x;
    s = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2 + 64'h2000_0000) >> 30) / ((2 * k) * (2 * k + 1));
      s = (k & 1) ? s - term : s + term;
    end
    term = 64'h4000_0000;
    c = term;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2 + 64'h2000_0000) >> 30) / ((2 * k - 1) * (2 * k));
      c = (k & 1) ? c - term : c + term;
    end
    if (swap) begin
      tmp = s; s = c; c = tmp;
    end
    case (quad)
      QUAD_0:  begin sn = s;  cs = c;  end
      QUAD_1:  begin sn = c;  cs = -s; end
      QUAD_2:  begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s;  end
    endcase
  endtask

  // Q30 to Q1.16, clamped to +-1 and rounded half away from zero.
  function automatic longint to_q16(longint v);
    longint unsigned m;
    if (v > 64'sh4000_0000) v = 64'sh4000_0000;
    if (v < -64'sh4000_0000) v = -64'sh4000_0000;
    m = ((v < 0 ? -v : v) + 64'd8192) >> 14;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Predict the four words of one angle triple and queue them.
  task automatic predict_composition(input logic [15:0] a, b, c);
    longint sn[3], cs[3], sq[3], cq[3], pp[3], w[4], d[4][3], wo[4];
    longint sum, dev, sab;
    logic [15:0] ang[3];
    bit bad;
    word_t wd;
    ang[0] = a; ang[1] = b; ang[2] = c;
    for (int i = 0; i < 3; i++) begin
      turn_sincos(ang[i], sn[i], cs[i]);
      sq[i] = mulq30(sn[i], sn[i]);
      cq[i] = mulq30(cs[i], cs[i]);
      pp[i] = 2 * mulq30(sn[i], cs[i]);
    end
    sab = mulq30(sq[0], sq[1]);
    w[0] = cq[0];
    w[1] = mulq30(sq[0], cq[1]);
    w[2] = mulq30(sab, cq[2]);
    w[3] = mulq30(sab, sq[2]);
    d[0][0] = -pp[0]; d[0][1] = 0; d[0][2] = 0;
    d[1][0] = mulq30(pp[0], cq[1]);
    d[1][1] = -mulq30(pp[1], sq[0]);
    d[1][2] = 0;
    d[2][0] = mulq30(mulq30(pp[0], sq[1]), cq[2]);
    d[2][1] = mulq30(mulq30(pp[1], sq[0]), cq[2]);
    d[2][2] = -mulq30(mulq30(pp[2], sq[0]), sq[1]);
    d[3][0] = mulq30(mulq30(pp[0], sq[1]), sq[2]);
    d[3][1] = mulq30(mulq30(pp[1], sq[0]), sq[2]);
    d[3][2] = mulq30(mulq30(pp[2], sq[0]), sq[1]);
    bad = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      wo[i] = to_q16(w[i]);
      if (wo[i] == 0) bad = 1;
      sum += wo[i];
    end
    dev = sum - 65536;
    if ((dev < 0 ? -dev : dev) > longint'(tol_model)) bad = 1;
    for (int i = 0; i < 4; i++) begin
      wd.idx = 2'(i);
      wd.w = 17'(wo[i]);
      wd.da = 18'(to_q16(d[i][0]));
      wd.db = 18'(to_q16(d[i][1]));
      wd.dc = 18'(to_q16(d[i][2]));
      wd.bad = bad;
      wd.last = (2'(i) == LAST_IDX);
      expected_words.push_back(wd);
    end
  endtask

  // Offer one triple with a random gap before it; wait until it is taken.
  // Valid stays high after the accepting edge only when the next triple follows at once.
  task automatic send_angles(input logic [15:0] a, b, c);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_a_i <= a;
    angle_b_i <= b;
    angle_c_i <= c;
    predict_composition(a, b, c);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Change the tolerance once the pipeline has drained.
  task automatic write_tolerance(input logic [7:0] tol);
    in_valid_i <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= tol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_model = tol;
  endtask

  // Draw an angle, often near a quadrant or octant boundary.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver stall pattern; a long hold-off can be requested.
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk_i);
        hold_long = 0;
        out_stall_i <= 1'b0;
      end else begin
        hold = $urandom_range(0, 11);
        if ($urandom_range(0, 2) == 0) hold = 0;
        out_stall_i <= (hold != 0);
        for (int n = 1; n < hold; n++) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: index %0d weight %0d", component_index_o, weight_o);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (component_index_o !== exp_w.idx) begin
          $error("component_index exp %0d got %0d", exp_w.idx, component_index_o);
          errors++;
        end
        if (weight_o !== exp_w.w) begin
          $error("weight exp %0d got %0d", exp_w.w, weight_o);
          errors++;
        end
        if (deriv_by_a_o !== exp_w.da) begin
          $error("deriv_by_a exp %0d got %0d", $signed(exp_w.da), deriv_by_a_o);
          errors++;
        end
        if (deriv_by_b_o !== exp_w.db) begin
          $error("deriv_by_b exp %0d got %0d", $signed(exp_w.db), deriv_by_b_o);
          errors++;
        end
        if (deriv_by_c_o !== exp_w.dc) begin
          $error("deriv_by_c exp %0d got %0d", $signed(exp_w.dc), deriv_by_c_o);
          errors++;
        end
        if (invalid_o !== exp_w.bad) begin
          $error("invalid exp %0d got %0d", exp_w.bad, invalid_o);
          errors++;
        end
        if (last_o !== exp_w.last) begin
          $error("last exp %0d got %0d", exp_w.last, last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= TIMEOUT_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  row_t directed[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 17'h10000},  // weight 0 is one, rest zero
    '{16'h8000, 16'h0000, 16'h0000, 1'b1, 17'h10000},  // half turn
    '{16'h4000, 16'h0000, 16'h0000, 1'b1, 17'h00000},  // quarter turn
    '{16'hC000, 16'h4000, 16'h0000, 1'b1, 17'h00000},
    '{16'h4000, 16'h4000, 16'h4000, 1'b1, 17'h00000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 17'h0},
    '{16'h2000, 16'h2000, 16'h2000, 1'b0, 17'h0},      // octant boundary
    '{16'h2001, 16'h1FFF, 16'h6000, 1'b0, 17'h0},
    '{16'h1000, 16'h3000, 16'h5000, 1'b0, 17'h0},
    '{16'hA000, 16'hE000, 16'h9000, 1'b0, 17'h0},
    '{16'h5555, 16'hAAAA, 16'h0F0F, 1'b0, 17'h0},
    '{16'h0001, 16'h8001, 16'h7FFF, 1'b0, 17'h0},
    '{16'h3000, 16'h2800, 16'h2000, 1'b0, 17'h0}
  };

  initial begin
    logic [7:0] tols[5];
    tols = '{8'd0, 8'd255, 8'd1, 8'd4, 8'd16};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset tolerance.
    foreach (directed[i]) begin
      send_angles(directed[i].a, directed[i].b, directed[i].c);
      if (directed[i].has_w0 &&
          expected_words[expected_words.size() - 4].w !== directed[i].w0) begin
        $error("weight table row %0d exp %0d predicted %0d", i, directed[i].w0,
               expected_words[expected_words.size() - 4].w);
        errors++;
      end
    end

    // Random phases over several tolerances; one long receiver hold-off.
    for (int p = 0; p < 5; p++) begin
      write_tolerance(tols[p]);
      if (p == 2) hold_long = 1;
      for (int n = 0; n < TOTAL_RANDOM / 5; n++)
        send_angles(pick_angle(), pick_angle(), pick_angle());
    end

    in_valid_i <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/atsj_pkg.sv
rtl/atsj_sincos.sv
rtl/atsj_jacob.sv
rtl/atsj_outconv.sv
rtl/atsj_ser.sv
rtl/angles_to_simplex_with_jacobian.sv
rtl/atsj_checker.sv
dv/angles_to_simplex_with_jacobian_tb.sv
